// ----- design/btok_pkg.sv -----
// Shared types, constants and character codes for the bencode tokenizer.
// No dependencies; every other design file imports this package.
package btok_pkg;

   localparam int MAX_DEPTH      = 32;
   localparam int MAX_INT_DIGITS = 23;

   localparam int BYTE_W   = 8;
   localparam int POS_W    = 32;
   localparam int STACK_AW = $clog2(MAX_DEPTH);
   localparam int DEPTH_W  = $clog2(MAX_DEPTH + 1);
   localparam int DIGIT_W  = $clog2(MAX_INT_DIGITS + 1);

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [BYTE_W-1:0] STRING_LIMIT_RESET = 8'hFF;

   localparam logic [BYTE_W-1:0] CHAR_0     = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_9     = 8'h39;
   localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3A;
   localparam logic [BYTE_W-1:0] CHAR_D     = 8'h64;
   localparam logic [BYTE_W-1:0] CHAR_E     = 8'h65;
   localparam logic [BYTE_W-1:0] CHAR_I     = 8'h69;
   localparam logic [BYTE_W-1:0] CHAR_L     = 8'h6C;

   typedef enum logic [2:0] {
      TOK_DICT_OPEN = 3'd0,
      TOK_LIST_OPEN = 3'd1,
      TOK_INT_BYTE  = 3'd2,
      TOK_INT_DONE  = 3'd3,
      TOK_STR_BYTE  = 3'd4,
      TOK_STR_EMPTY = 3'd5,
      TOK_END       = 3'd6
   } token_kind_type;

   typedef enum logic [1:0] {
      DERR_NONE      = 2'd0,
      DERR_UNDERFLOW = 2'd1,
      DERR_OVERFLOW  = 2'd2
   } depth_error_type;

   typedef struct packed {
      token_kind_type    kind;
      logic [BYTE_W-1:0] data_byte;
      logic [POS_W-1:0]  position;
      logic [POS_W-1:0]  opener_position;
      logic              token_last;
      depth_error_type   depth_error;
      logic              last_of_run;
   } token_type;

   // Up to two tokens per accepted byte, first in stream order.
   typedef struct packed {
      logic [1:0] count;
      token_type  first;
      token_type  second;
   } emit_type;

   typedef struct packed {
      logic             clear;
      logic             push;
      logic             pop;
      logic [POS_W-1:0] data;
   } stack_req_type;

   typedef struct packed {
      logic [DEPTH_W-1:0] depth;
      logic [POS_W-1:0]   top;
   } stack_stat_type;

endpackage

// ----- design/btok_stack.sv -----
// Opener position stack: memory array plus a registered top-of-stack copy.
// Depends on btok_pkg.
module btok_stack
   import btok_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  stack_req_type  stack_req,
   output stack_stat_type stack_stat
);

   logic [POS_W-1:0]    mem [MAX_DEPTH];
   logic [DEPTH_W-1:0]  depth_ff, depth_in, base;
   logic [POS_W-1:0]    top_ff;
   logic [STACK_AW-1:0] rd_addr;
   logic [DEPTH_W-1:0]  rd_full;

   always_comb begin
      base = stack_req.clear ? '0 : depth_ff;
      depth_in = base;
      if (stack_req.push) begin
         depth_in = base + DEPTH_W'(1);
      end else if (stack_req.pop) begin
         depth_in = base - DEPTH_W'(1);
      end
      // read ahead the entry that will be on top next cycle
      rd_full = depth_in - DEPTH_W'(1);
      rd_addr = rd_full[STACK_AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else begin
         depth_ff <= depth_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stack_req.push) begin
         mem[base[STACK_AW-1:0]] <= stack_req.data;
      end
      // new push bypasses the array read
      top_ff <= stack_req.push ? stack_req.data : mem[rd_addr];
   end

   assign stack_stat.depth = depth_ff;
   assign stack_stat.top   = top_ff;

endmodule

// ----- design/btok_core.sv -----
// Parser state and per-byte token logic; drives the opener stack.
// Depends on btok_pkg.
module btok_core
   import btok_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic [BYTE_W-1:0] in_byte,
   input  logic              start_of_file,
   input  logic              csr_we,
   input  logic [BYTE_W-1:0] csr_wdata,
   input  stack_stat_type    stack_stat,
   output stack_req_type     stack_req,
   output emit_type          emit
);

   typedef enum logic [1:0] {
      MODE_NORMAL,
      MODE_INT,
      MODE_STR,
      MODE_SKIP
   } mode_type;

   mode_type           mode_ff, mode_in, mode_eff;
   logic [POS_W-1:0]   bytepos_ff, bytepos_in, bytepos_eff;
   logic [POS_W-1:0]   accum_ff, accum_in, accum_eff;
   logic [POS_W-1:0]   remain_ff, remain_in, remain_eff, remain_dec;
   logic [DIGIT_W-1:0] digits_ff, digits_in, digits_eff;
   logic [POS_W-1:0]   strpos_ff, strpos_in, strpos_eff;
   logic [BYTE_W-1:0]  limit_ff, limit_in;
   logic [DEPTH_W-1:0] depth_eff;
   logic               full, nonempty;
   logic [POS_W-1:0]   pos;
   logic [POS_W+3:0]   times_ten;
   logic [1:0]         n;
   token_type          tok0, tok1, end_tok;

   always_comb begin
      mode_eff    = start_of_file ? MODE_NORMAL : mode_ff;
      bytepos_eff = start_of_file ? '0 : bytepos_ff;
      accum_eff   = start_of_file ? '0 : accum_ff;
      remain_eff  = start_of_file ? '0 : remain_ff;
      digits_eff  = start_of_file ? '0 : digits_ff;
      strpos_eff  = start_of_file ? '0 : strpos_ff;
      depth_eff   = start_of_file ? '0 : stack_stat.depth;
      full        = depth_eff >= DEPTH_W'(MAX_DEPTH);
      nonempty    = depth_eff != '0;
      pos         = bytepos_eff + POS_W'(1);
      remain_dec  = (remain_eff != '0) ? remain_eff - POS_W'(1) : '0;
      // accum * 10 + digit, as shift-and-add
      times_ten   = {3'b000, accum_eff, 1'b0} + {1'b0, accum_eff, 3'b000}
                  + {{POS_W{1'b0}}, in_byte[3:0]};

      end_tok.kind            = TOK_END;
      end_tok.data_byte       = '0;
      end_tok.position        = pos;
      end_tok.opener_position = nonempty ? stack_stat.top : '0;
      end_tok.token_last      = 1'b0;
      end_tok.depth_error     = nonempty ? DERR_NONE : DERR_UNDERFLOW;
      end_tok.last_of_run     = 1'b0;

      tok0 = '0;
      tok1 = '0;
      n    = 2'd0;
      stack_req.clear = en & start_of_file;
      stack_req.push  = 1'b0;
      stack_req.pop   = 1'b0;
      stack_req.data  = pos;

      mode_in    = mode_eff;
      bytepos_in = pos;
      accum_in   = accum_eff;
      remain_in  = remain_eff;
      digits_in  = digits_eff;
      strpos_in  = strpos_eff;

      unique case (mode_eff)
         MODE_STR: begin
            remain_in       = remain_dec;
            tok0.kind       = TOK_STR_BYTE;
            tok0.data_byte  = in_byte;
            tok0.position   = strpos_eff;
            tok0.token_last = remain_dec == '0;
            n               = 2'd1;
            if (remain_dec == '0) begin
               mode_in = MODE_NORMAL;
            end
         end
         MODE_SKIP: begin
            remain_in = remain_dec;
            if (remain_dec == '0) begin
               mode_in = MODE_NORMAL;
            end
         end
         MODE_INT: begin
            if (in_byte == CHAR_E) begin
               tok0.kind     = TOK_INT_DONE;
               tok0.position = strpos_eff;
               tok1          = end_tok;
               n             = 2'd2;
               stack_req.pop = en & nonempty;
               digits_in     = '0;
               mode_in       = MODE_NORMAL;
            end else if (digits_eff < DIGIT_W'(MAX_INT_DIGITS)) begin
               tok0.kind      = TOK_INT_BYTE;
               tok0.data_byte = in_byte;
               tok0.position  = strpos_eff;
               n              = 2'd1;
               digits_in      = digits_eff + DIGIT_W'(1);
            end
         end
         MODE_NORMAL: begin
            priority if (in_byte >= CHAR_0 && in_byte <= CHAR_9) begin
               accum_in = (times_ten[POS_W+3:POS_W] != '0) ? '1 : times_ten[POS_W-1:0];
            end else if (in_byte == CHAR_COLON) begin
               accum_in  = '0;
               strpos_in = pos + POS_W'(1);
               if (accum_eff > {{(POS_W-BYTE_W){1'b0}}, limit_ff}) begin
                  remain_in = accum_eff;
                  mode_in   = MODE_SKIP;
               end else if (accum_eff == '0) begin
                  tok0.kind     = TOK_STR_EMPTY;
                  tok0.position = pos + POS_W'(1);
                  n             = 2'd1;
               end else begin
                  remain_in = accum_eff;
                  mode_in   = MODE_STR;
               end
            end else if (in_byte == CHAR_I) begin
               accum_in       = '0;
               stack_req.push = en & ~full;
               strpos_in      = pos;
               digits_in      = '0;
               mode_in        = MODE_INT;
            end else if (in_byte == CHAR_D || in_byte == CHAR_L) begin
               stack_req.push   = en & ~full;
               tok0.kind        = (in_byte == CHAR_D) ? TOK_DICT_OPEN : TOK_LIST_OPEN;
               tok0.position    = pos;
               tok0.depth_error = full ? DERR_OVERFLOW : DERR_NONE;
               n                = 2'd1;
            end else if (in_byte == CHAR_E) begin
               tok0          = end_tok;
               stack_req.pop = en & nonempty;
               n             = 2'd1;
            end else begin
               n = 2'd0;
            end
         end
         default: begin
            mode_in = MODE_NORMAL;
         end
      endcase

      if (n == 2'd1) begin
         tok0.last_of_run = 1'b1;
      end
      if (n == 2'd2) begin
         tok1.last_of_run = 1'b1;
      end

      emit.count  = en ? n : 2'd0;
      emit.first  = tok0;
      emit.second = tok1;

      limit_in = csr_we ? csr_wdata : limit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_NORMAL;
         bytepos_ff <= '0;
         accum_ff   <= '0;
         remain_ff  <= '0;
         digits_ff  <= '0;
         strpos_ff  <= '0;
         limit_ff   <= STRING_LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
         if (en) begin
            mode_ff    <= mode_in;
            bytepos_ff <= bytepos_in;
            accum_ff   <= accum_in;
            remain_ff  <= remain_in;
            digits_ff  <= digits_in;
            strpos_ff  <= strpos_in;
         end
      end
   end

endmodule

// ----- design/btok_outq.sv -----
// Result queue: takes up to two tokens per cycle, delivers one per cycle while out_ready is high.
// Depends on btok_pkg.
module btok_outq
   import btok_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  emit_type  emit,
   input  logic      out_ready,
   output logic      out_valid,
   output token_type out_token,
   output logic      has_room
);

   token_type           slots [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QUEUE_CW-1:0] count_ff, count_in;
   logic                pop;

   always_comb begin
      pop      = out_valid & out_ready;
      wr_in    = wr_ff + QUEUE_AW'(emit.count);
      rd_in    = rd_ff + QUEUE_AW'(pop);
      count_in = count_ff + QUEUE_CW'(emit.count) - QUEUE_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.count != 2'd0) begin
         slots[wr_ff] <= emit.first;
      end
      if (emit.count == 2'd2) begin
         slots[wr_ff + QUEUE_AW'(1)] <= emit.second;
      end
   end

   assign out_valid = count_ff != '0;
   assign out_token = slots[rd_ff];
   assign has_room  = count_ff <= QUEUE_CW'(QUEUE_DEPTH - 2);

endmodule

// ----- design/bencode_tokenizer.sv -----
// Top level of the bencode tokenizer: byte stream in, token stream out.
// Depends on btok_pkg, btok_stack, btok_core and btok_outq.
//
// Takes one byte of a bencoded stream per cycle while req_tready is high and
// turns it into tokens (dict/list open, integer bytes, integer done, string
// bytes, empty string, end). Each accepted byte is fully decoded in the cycle
// it is taken; its tokens land in a four-entry result queue and go out on
// rsp in order. A byte gives zero, one or two tokens; only the 'e' that
// closes an integer gives two. The input takes a byte every cycle while the
// queue has room for two tokens. An integer close always follows an 'i' that
// gives no token, so while rsp is ready the queue never backs up and the
// sustained rate is one byte per cycle; only rsp back-pressure stalls the
// input. Opener positions sit in a 32-entry stack; its top is kept in a
// register read ahead from the array, so pushes and pops never stall input.
// There is no clearing pass after reset. start_of_file on a byte wipes all
// parser state before that byte; string_limit survives it. Write string_limit
// only while the block is idle.
module bencode_tokenizer
   import btok_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input bytes
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tuser,   // [0] start_of_file
   // tokens
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [7:0] data_byte, [39:8] position,
                                    // [71:40] opener_position
   output logic [5:0]  rsp_tuser,   // [2:0] token_kind, [3] token_last,
                                    // [5:4] depth_error
   output logic        rsp_tlast,   // last_of_run
   // string_limit register
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata
);

   logic           accept;
   stack_req_type  stack_req;
   stack_stat_type stack_stat;
   emit_type       emit;
   token_type      head;
   logic           has_room;

   assign accept     = req_tvalid & req_tready;
   assign req_tready = has_room;

   btok_core u_core (
      .clock         (clock),
      .reset         (reset),
      .en            (accept),
      .in_byte       (req_tdata),
      .start_of_file (req_tuser),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .stack_stat    (stack_stat),
      .stack_req     (stack_req),
      .emit          (emit)
   );

   btok_stack u_stack (
      .clock      (clock),
      .reset      (reset),
      .stack_req  (stack_req),
      .stack_stat (stack_stat)
   );

   btok_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .emit      (emit),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_token (head),
      .has_room  (has_room)
   );

   assign rsp_tdata = {head.opener_position, head.position, head.data_byte};
   assign rsp_tuser = {head.depth_error, head.token_last, head.kind};
   assign rsp_tlast = head.last_of_run;

   // after any token is produced, rsp_tvalid is high on the next cycle
   a_emit_visible: assert property (@(posedge clock) disable iff (reset)
      (emit.count != 2'd0) |=> rsp_tvalid)
      else $error("emitted token not visible on rsp");

   // integer done is always followed by its end token in the same run
   a_int_done_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && head.kind == TOK_INT_DONE) |-> !rsp_tlast)
      else $error("int done marked last of run");

   // only an integer close produces two tokens
   a_pair_is_int_close: assert property (@(posedge clock) disable iff (reset)
      (emit.count == 2'd2) |-> (emit.first.kind == TOK_INT_DONE &&
                                emit.second.kind == TOK_END))
      else $error("unexpected token pair");

   // input is only held off while tokens are waiting
   a_stall_has_backlog: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with empty queue");

endmodule

// ----- bench/bencode_tokenizer_tb.sv -----
// Self-checking bench for bencode_tokenizer: directed and random byte streams in, tokens out.
// Depends on btok_pkg and the bencode_tokenizer RTL. It carries its own token predictor.
module bencode_tokenizer_tb;
   import btok_pkg::*;

   localparam int LIMIT_CYCLES = 400000;
   localparam int QUIET_NEEDED = 8;     // settle time before a string_limit write
   localparam int PHASE_BYTES  = 155;

   // Entries of the stimulus queue: a stream byte, a register write, or a
   // pause until every predicted token has come out.
   typedef enum logic [1:0] {STIM_BYTE, STIM_CSR, STIM_DRAIN} stim_kind_type;
   typedef struct packed {
      stim_kind_type kind;
      logic [7:0]    value;
      logic          sof;
   } stim_type;

   typedef enum logic [1:0] {MODE_NORMAL, MODE_INT, MODE_STR, MODE_SKIP} parse_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic [5:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [7:0]  csr_wdata = 8'd0;

   bencode_tokenizer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   stim_type  stim_q[$];
   token_type token_q[$];     // predicted tokens, oldest first

   int  bytes_queued = 0;
   int  total_bytes  = 0;
   int  sent_count   = 0;
   int  fail_count   = 0;
   int  cycle_count  = 0;
   int  send_gap     = 0;
   int  stall_left   = 0;
   int  quiet_cycles = 0;
   bit  req_fired    = 1'b0;  // set at the edge that takes an item, cleared by the driver

   // ---------------------------------------------------------------------
   // Parser copy used for prediction
   // ---------------------------------------------------------------------
   logic [7:0]     cur_limit;
   parse_mode_type mode;
   logic [31:0]    byte_pos;
   logic [31:0]    len_acc;
   logic [31:0]    remaining;
   int             digits;
   logic [31:0]    str_pos;
   logic [31:0]    opener_stack [MAX_DEPTH];
   int             depth;

   task automatic clear_parser();
      mode      = MODE_NORMAL;
      byte_pos  = '0;
      len_acc   = '0;
      remaining = '0;
      digits    = 0;
      str_pos   = '0;
      depth     = 0;
   endtask

   function automatic token_type make_tok(token_kind_type kind, logic [7:0] data,
                                          logic [31:0] pos, logic [31:0] opos,
                                          logic last, depth_error_type err);
      token_type t;
      t.kind            = kind;
      t.data_byte       = data;
      t.position        = pos;
      t.opener_position = opos;
      t.token_last      = last;
      t.depth_error     = err;
      t.last_of_run     = 1'b0;
      return t;
   endfunction

   // An 'e' pops the innermost opener; with nothing open it reports underflow.
   task automatic close_level(input logic [31:0] at, output token_type t);
      if (depth > 0) begin
         depth--;
         t = make_tok(TOK_END, 8'd0, at, opener_stack[depth], 1'b0, DERR_NONE);
      end else begin
         t = make_tok(TOK_END, 8'd0, at, 32'd0, 1'b0, DERR_UNDERFLOW);
      end
   endtask

   // Advance the parser copy by one byte and queue the tokens it yields.
   task automatic tokenize_byte(input logic [7:0] c, input logic sof);
      token_type   pend [0:1];
      int          n;
      logic [35:0] grown;
      logic [31:0] len;
      n = 0;
      if (sof)
         clear_parser();
      byte_pos = byte_pos + 32'd1;
      case (mode)
         MODE_STR: begin
            if (remaining != 0)
               remaining = remaining - 32'd1;
            pend[n] = make_tok(TOK_STR_BYTE, c, str_pos, 32'd0, remaining == 0, DERR_NONE);
            n++;
            if (remaining == 0)
               mode = MODE_NORMAL;
         end
         MODE_SKIP: begin
            if (remaining != 0)
               remaining = remaining - 32'd1;
            if (remaining == 0)
               mode = MODE_NORMAL;
         end
         MODE_INT: begin
            if (c == CHAR_E) begin
               // int done, then the end token that pops the 'i'
               pend[n] = make_tok(TOK_INT_DONE, 8'd0, str_pos, 32'd0, 1'b0, DERR_NONE);
               n++;
               close_level(byte_pos, pend[n]);
               n++;
               digits = 0;
               mode   = MODE_NORMAL;
            end else if (digits < MAX_INT_DIGITS) begin
               pend[n] = make_tok(TOK_INT_BYTE, c, str_pos, 32'd0, 1'b0, DERR_NONE);
               n++;
               digits++;
            end
         end
         default: begin
            if (c >= CHAR_0 && c <= CHAR_9) begin
               // length accumulator saturates instead of wrapping
               grown   = {4'd0, len_acc} * 36'd10 + {28'd0, c - CHAR_0};
               len_acc = (grown > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF : grown[31:0];
            end else if (c == CHAR_COLON) begin
               len     = len_acc;
               len_acc = '0;
               str_pos = byte_pos + 32'd1;
               if (len > {24'd0, cur_limit}) begin
                  remaining = len;
                  mode      = MODE_SKIP;
               end else if (len == 0) begin
                  pend[n] = make_tok(TOK_STR_EMPTY, 8'd0, str_pos, 32'd0, 1'b0, DERR_NONE);
                  n++;
               end else begin
                  remaining = len;
                  mode      = MODE_STR;
               end
            end else if (c == CHAR_I) begin
               // a full stack drops the 'i' silently
               len_acc = '0;
               if (depth < MAX_DEPTH) begin
                  opener_stack[depth] = byte_pos;
                  depth++;
               end
               str_pos = byte_pos;
               digits  = 0;
               mode    = MODE_INT;
            end else if (c == CHAR_D || c == CHAR_L) begin
               pend[n] = make_tok(c == CHAR_D ? TOK_DICT_OPEN : TOK_LIST_OPEN, 8'd0, byte_pos,
                                  32'd0, 1'b0, depth < MAX_DEPTH ? DERR_NONE : DERR_OVERFLOW);
               n++;
               if (depth < MAX_DEPTH) begin
                  opener_stack[depth] = byte_pos;
                  depth++;
               end
            end else if (c == CHAR_E) begin
               close_level(byte_pos, pend[n]);
               n++;
            end
         end
      endcase
      if (n > 0)
         pend[n-1].last_of_run = 1'b1;
      for (int k = 0; k < n; k++)
         token_q.push_back(pend[k]);
   endtask

   // ---------------------------------------------------------------------
   // Stimulus construction
   // ---------------------------------------------------------------------
   task automatic queue_byte(input logic [7:0] v, input logic sof);
      stim_q.push_back('{STIM_BYTE, v, sof});
      bytes_queued++;
   endtask

   task automatic queue_text(input string s);
      for (int k = 0; k < s.len(); k++)
         queue_byte(s[k], 1'b0);
   endtask

   // One well-formed value with random content. String lengths cluster
   // around the current limit now and then so both sides of it are hit.
   task automatic gen_value(input int lvl, input logic [7:0] lim);
      int r;
      int len;
      int cnt;
      logic [7:0] c;
      r = $urandom_range(0, 99);
      if (r < 30) begin
         cnt = $urandom_range(0, 99);
         if (cnt < 60)
            len = $urandom_range(0, 12);
         else if (cnt < 85)
            len = $urandom_range(lim < 2 ? 0 : lim - 2, lim + 2);
         else
            len = $urandom_range(0, 40);
         if ($urandom_range(0, 9) == 0)
            queue_text("0");
         queue_text($sformatf("%0d:", len));
         for (int k = 0; k < len; k++)
            queue_byte(8'($urandom_range(0, 255)), 1'b0);
      end else if (r < 55 || lvl >= 4) begin
         queue_byte(CHAR_I, 1'b0);
         if ($urandom_range(0, 3) == 0)
            queue_text("-");
         cnt = ($urandom_range(0, 9) < 6) ? $urandom_range(1, 6) : $urandom_range(20, 28);
         for (int k = 0; k < cnt; k++) begin
            if ($urandom_range(0, 11) == 0) begin
               // any non-'e' byte is still an integer byte
               do c = 8'($urandom_range(0, 255)); while (c == CHAR_E);
            end else begin
               c = CHAR_0 + 8'($urandom_range(0, 9));
            end
            queue_byte(c, 1'b0);
         end
         queue_byte(CHAR_E, 1'b0);
      end else begin
         r = $urandom_range(0, 1);
         queue_byte(r == 0 ? CHAR_D : CHAR_L, 1'b0);
         cnt = $urandom_range(0, 4);
         for (int k = 0; k < cnt; k++) begin
            if (r == 0)
               queue_text($sformatf("%0d:k%0d", 2 + k / 10, k));
            gen_value(lvl + 1, lim);
         end
         queue_byte(CHAR_E, 1'b0);
      end
   endtask

   // Broken or odd sequences. Random bytes leave digits out so stray lengths
   // cannot swallow the rest of the run; huge lengths are always followed by
   // a start-of-file byte that wipes the parser.
   task automatic gen_noise();
      int r;
      int cnt;
      logic [7:0] c;
      r = $urandom_range(0, 9);
      if (r < 5) begin
         cnt = $urandom_range(1, 6);
         for (int k = 0; k < cnt; k++) begin
            do c = 8'($urandom_range(0, 255)); while (c >= CHAR_0 && c <= CHAR_9);
            queue_byte(c, $urandom_range(0, 5) == 0);
         end
      end else if (r < 6) begin
         cnt = $urandom_range(1, 4);
         for (int k = 0; k < cnt; k++)
            queue_byte(CHAR_E, 1'b0);
      end else if (r < 7) begin
         // overflow on list, dict and int, then unwind past empty
         for (int k = 0; k < MAX_DEPTH + 1; k++)
            queue_byte(CHAR_L, 1'b0);
         queue_text("di4e");
         for (int k = 0; k < MAX_DEPTH + 1; k++)
            queue_byte(CHAR_E, 1'b0);
      end else if (r < 8) begin
         // length digits split by an opener join into one length
         queue_text("1l2:");
         for (int k = 0; k < 12; k++)
            queue_byte(8'($urandom_range(0, 255)), 1'b0);
         queue_byte(CHAR_E, 1'b0);
      end else if (r < 9) begin
         // saturation of the length accumulator
         case ($urandom_range(0, 3))
            0:       queue_text("4294967296:");
            1:       queue_text("4294967301:");
            2:       queue_text("99999999999:");
            default: queue_text("0000000000000004294967295:");
         endcase
         queue_text("ab");
         queue_byte("x", 1'b1);
      end else begin
         // truncated string
         queue_text("9:abc");
      end
   endtask

   // ---------------------------------------------------------------------
   // Input driver: changes at the falling edge
   // ---------------------------------------------------------------------
   function automatic bit idle_allowed();
      // idle stretches and calm stretches alternate; the tail runs flat out
      return (sent_count % 256) < 192 && sent_count + 100 < total_bytes;
   endfunction

   always @(negedge clock) begin
      logic     valid_nxt;
      logic     we_nxt;
      stim_type s;
      valid_nxt = req_tvalid;
      we_nxt    = 1'b0;
      if (token_q.size() == 0 && !req_tvalid && !rsp_tvalid)
         quiet_cycles++;
      else
         quiet_cycles = 0;
      if (reset) begin
         valid_nxt = 1'b0;
      end else begin
         if (req_fired) begin
            valid_nxt = 1'b0;
            req_fired = 1'b0;
         end
         if (!valid_nxt) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (stim_q.size() != 0) begin
               s = stim_q[0];
               case (s.kind)
                  STIM_BYTE: begin
                     req_tdata <= s.value;
                     req_tuser <= s.sof;
                     valid_nxt = 1'b1;
                     void'(stim_q.pop_front());
                     sent_count++;
                     if (idle_allowed() && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 14);
                  end
                  STIM_CSR: begin
                     // only once the token queue has drained and settled
                     if (quiet_cycles >= QUIET_NEEDED) begin
                        csr_wdata <= s.value;
                        we_nxt = 1'b1;
                        void'(stim_q.pop_front());
                     end
                  end
                  default: begin
                     if (token_q.size() == 0)
                        void'(stim_q.pop_front());
                  end
               endcase
            end
         end
      end
      req_tvalid <= valid_nxt;
      csr_we     <= we_nxt;
   end

   // Result side back-pressure in bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (idle_allowed() && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 14);
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: predicts on each accepted byte, checks each accepted token
   // ---------------------------------------------------------------------
   function automatic string tok_text(token_type t);
      return $sformatf("kind=%0d data=%02h pos=%0d opener=%0d last=%b err=%0d run_end=%b",
                       t.kind, t.data_byte, t.position, t.opener_position,
                       t.token_last, t.depth_error, t.last_of_run);
   endfunction

   always @(posedge clock) begin
      token_type got;
      token_type want;
      if (reset) begin
         clear_parser();
         cur_limit = STRING_LIMIT_RESET;
      end else begin
         if (csr_we)
            cur_limit = csr_wdata;
         if (req_tvalid && req_tready) begin
            tokenize_byte(req_tdata, req_tuser);
            req_fired = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.kind            = token_kind_type'(rsp_tuser[2:0]);
            got.data_byte       = rsp_tdata[7:0];
            got.position        = rsp_tdata[39:8];
            got.opener_position = rsp_tdata[71:40];
            got.token_last      = rsp_tuser[3];
            got.depth_error     = depth_error_type'(rsp_tuser[5:4]);
            got.last_of_run     = rsp_tlast;
            if (token_q.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected token: %s", tok_text(got));
               fail_count++;
            end else begin
               want = token_q.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display("token mismatch: expected %s, got %s",
                              tok_text(want), tok_text(got));
                  fail_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      logic [7:0] lim;
      int         goal;
      // Directed: underflow, empty string with and without digits, byte
      // extremes in a string, dict, negative int, nested ends, ignored byte.
      queue_byte(CHAR_E, 1'b1);
      queue_text(":l2:");
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_text("d0:i-07eeex");
      queue_byte(CHAR_L, 1'b1);
      queue_text("1:ze");
      goal = bytes_queued;
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0:       lim = 8'd255;
            1:       lim = 8'd0;
            2:       lim = 8'd1;
            3:       lim = 8'($urandom_range(2, 254));
            4:       lim = 8'd12;
            default: lim = 8'd255;
         endcase
         stim_q.push_back('{STIM_CSR, lim, 1'b0});
         goal += PHASE_BYTES;
         while (bytes_queued < goal) begin
            if ($urandom_range(0, 9) < 7)
               gen_value(0, lim);
            else
               gen_noise();
            // sender holds off mid-phase until all tokens are out
            if (bytes_queued > goal - PHASE_BYTES / 2 &&
                stim_q[$].kind == STIM_BYTE && $urandom_range(0, 5) == 0)
               stim_q.push_back('{STIM_DRAIN, 8'd0, 1'b0});
         end
      end
      total_bytes = bytes_queued;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (stim_q.size() != 0 || req_tvalid)
         @(posedge clock);
      while (token_q.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      if (token_q.size() != 0)
         $display("%0d tokens never arrived", token_q.size());
      fail_count += token_q.size();
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
